>>> src/led_pkg.sv
package led_pkg;

  localparam int BLK_W   = 64;
  localparam int KEY_W   = 64;
  localparam int CELL_W  = 4;
  localparam int NCELLS  = 16;
  localparam int RC_W    = 6;
  localparam int RC_LEN  = 48;
  localparam int CFG_IDX_W = 2;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [RC_W-1:0]   rc_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ONE = 2'd0,
    REG_KEY_TWO = 2'd1
  } cfg_reg_t;

  localparam rc_t RC_TABLE [RC_LEN] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  localparam cell_t SBOX [NCELLS] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam cell_t MDS [4][4] = '{
    '{4'h4, 4'h1, 4'h2, 4'h2},
    '{4'h8, 4'h6, 4'h5, 4'h6},
    '{4'hB, 4'hE, 4'hA, 4'h9},
    '{4'h2, 4'h2, 4'hF, 4'hB}
  };

  // multiply in GF(16) modulo x^4+x+1
  function automatic cell_t gf16_mul(input cell_t a, input cell_t b);
    logic [CELL_W:0] sh;
    cell_t           acc;
    acc = '0;
    sh  = {1'b0, a};
    for (int i = 0; i < CELL_W; i++) begin
      if (b[i]) acc = acc ^ sh[CELL_W-1:0];
      sh = sh << 1;
      if (sh[CELL_W]) sh = sh ^ 5'h13;
    end
    return acc;
  endfunction

  // one LED round: constants, S-box, row rotation, column mix
  function automatic blk_t led_round_f(input blk_t blk, input rc_t rc);
    blk_t        kc;
    blk_t        x;
    blk_t        s;
    blk_t        t;
    blk_t        m;
    logic [63:0] hi;
    logic [63:0] lo;
    cell_t       acc;
    hi = {61'd0, rc[5:3]};
    lo = {61'd0, rc[2:0]};
    kc = (lo << 8) | (64'd3 << 12) | (hi << 24) | (64'd2 << 28) |
         (lo << 40) | (64'd1 << 44) | (hi << 56);
    x = blk ^ kc;
    for (int n = 0; n < NCELLS; n++)
      s[63-4*n -: 4] = SBOX[x[63-4*n -: 4]];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[63-4*(r*4+c) -: 4] = s[63-4*(r*4+((c+r)%4)) -: 4];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++)
          acc = acc ^ gf16_mul(t[63-4*(j*4+c) -: 4], MDS[r][j]);
        m[63-4*(r*4+c) -: 4] = acc;
      end
    return m;
  endfunction

endpackage

>>> src/led_round_stage.sv
module led_round_stage import led_pkg::*; #(
  parameter int RND     = 0,
  parameter bit KEY_ADD = 1'b0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_in,
  input  blk_t blk_in,
  input  key_t key,
  output logic vld_out,
  output blk_t blk_out
);

  localparam rc_t RC = RC_TABLE[RND % RC_LEN];

  logic vld_r;
  blk_t blk_r;
  blk_t blk_nxt;

  always_comb begin
    blk_nxt = led_round_f(blk_in, RC);
    if (KEY_ADD) blk_nxt = blk_nxt ^ key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    blk_r <= blk_nxt;
  end

  assign vld_out = vld_r;
  assign blk_out = blk_r;

endmodule

>>> src/led128_block_encrypt.sv
// Channel   Ports                                   Handshake
// input     start, busy, in_plaintext[63:0]         taken when start && !busy
// result    out_valid, out_ciphertext[63:0]         one-cycle strobe, no backpressure
// config    cfg_we, cfg_index[1:0], cfg_wdata[63:0] written when cfg_we is high
//
// One item enters every cycle; busy is always low.
// The pipeline has one stage for the initial key add,
// then one register stage per round (48 at the default), the key half
// folded into the last round of each step.
// Reset (synchronous, rst_n low) clears the valid bits and both key halves.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module led128_block_encrypt import led_pkg::*; #(
  parameter int ROUNDS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [BLK_W-1:0]     in_plaintext,
  output logic                 out_valid,
  output logic [BLK_W-1:0]     out_ciphertext,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata
);

  localparam int NSTEPS  = ROUNDS / 4;
  localparam int NROUNDS = NSTEPS * 4;
  localparam int LAT     = NROUNDS + 1;

  key_t key_one_r;
  key_t key_two_r;
  logic accept;

  // vld[0]/blk[0] is the key-add stage, vld[g+1]/blk[g+1] is round g
  logic vld [NROUNDS+1];
  blk_t blk [NROUNDS+1];

  logic vld0_r;
  blk_t blk0_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // key registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r <= '0;
      key_two_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_ONE: key_one_r <= cfg_wdata;
        REG_KEY_TWO: key_two_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // entry stage: whiten with the first key half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
    blk0_r <= in_plaintext ^ key_one_r;
  end

  assign vld[0] = vld0_r;
  assign blk[0] = blk0_r;

  // round stages; the last round of each step adds a key half,
  // the second half after even steps and the first after odd ones
  for (genvar g = 0; g < NROUNDS; g++) begin : g_rnd
    led_round_stage #(
      .RND     (g),
      .KEY_ADD ((g % 4) == 3)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld[g]),
      .blk_in  (blk[g]),
      .key     ((((g / 4) % 2) == 1) ? key_one_r : key_two_r),
      .vld_out (vld[g+1]),
      .blk_out (blk[g+1])
    );
  end

  assign out_valid      = vld[NROUNDS];
  assign out_ciphertext = blk[NROUNDS];

  // a result only ever comes from an item taken earlier, through the key-add stage and every round stage
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching item");

  a_key_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_KEY_ONE) |=> key_one_r == $past(cfg_wdata))
    else $error("first key half not written");

  a_key_two_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_KEY_TWO) |=> key_two_r == $past(cfg_wdata))
    else $error("second key half not written");

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index != REG_KEY_ONE && cfg_index != REG_KEY_TWO)
      |=> ($stable(key_one_r) && $stable(key_two_r)))
    else $error("write to unknown index changed a key");

endmodule
